### rtl/core/oal_pkg.sv
package oal_pkg;

    localparam int POS_W = 8;
    localparam int KEY_W = 32;
    localparam int PAY_W = 64;
    localparam int FPOS_W = 7;
    localparam int OCC_W = 8;

    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_REMOVE = 2'd1;
    localparam logic [1:0] KIND_SEARCH = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;
    localparam logic [1:0] ST_MISS  = 2'd3;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_REMOVE
    } op_t;

    typedef enum logic {
        S_IDLE,
        S_SEARCH
    } state_t;

    typedef struct packed {
        op_t              op;
        logic [POS_W-1:0] position;
        logic [KEY_W-1:0] key;
        logic [PAY_W-1:0] payload;
    } cell_cmd_t;

    typedef struct packed {
        logic             active;
        logic             found;
        logic [PAY_W-1:0] payload;
    } token_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [FPOS_W-1:0] found_position;
        logic [PAY_W-1:0]  found_payload;
        logic [OCC_W-1:0]  occupancy;
    } result_t;

endpackage

### rtl/core/oal_cell.sv
module oal_cell import oal_pkg::*; #(
    parameter int CNT_W = 8,
    parameter int IDX_W = 7,
    parameter int INDEX = 0
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  cell_cmd_t        cmd,
    input  logic [CNT_W-1:0] count,
    input  logic [KEY_W-1:0] query_key,
    input  logic [KEY_W-1:0] left_key,
    input  logic [PAY_W-1:0] left_payload,
    input  logic [KEY_W-1:0] right_key,
    input  logic [PAY_W-1:0] right_payload,
    input  token_t           tok_in,
    input  logic [IDX_W-1:0] tok_pos_in,
    output logic [KEY_W-1:0] key,
    output logic [PAY_W-1:0] payload,
    output token_t           tok_out,
    output logic [IDX_W-1:0] tok_pos_out
);

    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    logic [KEY_W-1:0] key_reg, key_next;
    logic [PAY_W-1:0] payload_reg, payload_next;
    logic             active_reg;
    logic             found_reg, found_next;
    logic [PAY_W-1:0] tpay_reg, tpay_next;
    logic [IDX_W-1:0] tpos_reg, tpos_next;

    logic [CMP_W-1:0] idx;
    logic [CMP_W-1:0] pos_ext;
    logic [CMP_W-1:0] cnt_ext;
    logic             hit;

    assign idx     = CMP_W'(INDEX);
    assign pos_ext = CMP_W'(cmd.position);
    assign cnt_ext = CMP_W'(count);
    assign hit     = tok_in.active && !tok_in.found && (idx < cnt_ext) && (key_reg == query_key);

    always_comb begin
        key_next     = key_reg;
        payload_next = payload_reg;
        case (cmd.op)
            OP_INSERT: begin
                if (idx > pos_ext) begin
                    key_next     = left_key;
                    payload_next = left_payload;
                end else if (idx == pos_ext) begin
                    key_next     = cmd.key;
                    payload_next = cmd.payload;
                end
            end
            OP_REMOVE: begin
                if (idx >= pos_ext) begin
                    key_next     = right_key;
                    payload_next = right_payload;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        found_next = tok_in.found;
        tpay_next  = tok_in.payload;
        tpos_next  = tok_pos_in;
        if (hit) begin
            found_next = 1'b1;
            tpay_next  = payload_reg;
            tpos_next  = IDX_W'(INDEX);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
        end else begin
            active_reg <= tok_in.active;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg     <= key_next;
        payload_reg <= payload_next;
        found_reg   <= found_next;
        tpay_reg    <= tpay_next;
        tpos_reg    <= tpos_next;
    end

    assign key                 = key_reg;
    assign payload             = payload_reg;
    assign tok_out.active      = active_reg;
    assign tok_out.found       = found_reg;
    assign tok_out.payload     = tpay_reg;
    assign tok_pos_out         = tpos_reg;

endmodule

### rtl/core/ordered_array_list_top.sv
// Ordered list of key/payload entries with positional insert, remove and key search.
// Requests arrive on the s_ stream: s_tuser carries the request kind and s_tdata
// the position, key and payload. Every request yields exactly one result word on
// the m_ stream, with the status in m_tuser and the search result and occupancy
// in m_tdata.
// Insert and remove shift all cells together, so their result word enters the
// output buffer in the cycle after acceptance. A search sends a query token down
// the row of cells, one cell a cycle, and its result enters the output buffer once
// the token leaves the last cell; no new request is taken while a search is in flight.
// Throughput is one insert or remove per cycle while the output buffer has room;
// a search holds off every new request until its token leaves the cell chain.
// Results go into a two-word output buffer, so a request is taken while an
// earlier result waits. When the receiver stalls and both words are held,
// s_tready stays low until a word drains.
// Reset empties the list and the output buffer; stored entries are not cleared.
module ordered_array_list_top import oal_pkg::*; #(
    parameter int CAPACITY = 128
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [103:0] s_tdata,  // position[7:0], entry_key[39:8], entry_payload[103:40]
    input  logic [1:0]   s_tuser,  // kind[1:0]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [79:0]  m_tdata,  // found_position[6:0], found_payload[70:7], occupancy[78:71]
    output logic [1:0]   m_tuser   // status[1:0]
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [KEY_W-1:0] qkey_reg;
    logic             inject_reg;
    logic [1:0]       fifo_cnt_reg, fifo_cnt_next;
    result_t          slot0_reg, slot0_next;
    result_t          slot1_reg, slot1_next;

    logic [1:0]       in_kind;
    logic [POS_W-1:0] in_pos;
    logic [KEY_W-1:0] in_key;
    logic [PAY_W-1:0] in_payload;
    logic             in_acc;
    logic             deq;
    logic             enq;
    result_t          enq_data;
    result_t          imm_res;
    result_t          srch_res;
    cell_cmd_t        cmd;
    logic [CMP_W-1:0] pos_ext;
    logic [CMP_W-1:0] cnt_ext;
    logic             full;
    logic             done;

    logic [KEY_W-1:0] cell_key [CAPACITY];
    logic [PAY_W-1:0] cell_payload [CAPACITY];
    token_t           tok [CAPACITY+1];
    logic [IDX_W-1:0] tok_pos [CAPACITY+1];

    assign in_kind    = s_tuser;
    assign in_pos     = s_tdata[7:0];
    assign in_key     = s_tdata[39:8];
    assign in_payload = s_tdata[103:40];

    assign in_acc  = s_tvalid && s_tready;
    assign deq     = m_tvalid && m_tready;
    assign pos_ext = CMP_W'(in_pos);
    assign cnt_ext = CMP_W'(count_reg);
    assign full    = (count_reg == CNT_W'(CAPACITY));
    assign done    = tok[CAPACITY].active;

    always_comb begin
        cmd.op         = OP_HOLD;
        cmd.position   = in_pos;
        cmd.key        = in_key;
        cmd.payload    = in_payload;
        count_next     = count_reg;
        imm_res.status = ST_OK;
        case (in_kind)
            KIND_INSERT: begin
                if (full) begin
                    imm_res.status = ST_FULL;
                end else if (pos_ext > cnt_ext) begin
                    imm_res.status = ST_RANGE;
                end else if (in_acc) begin
                    cmd.op     = OP_INSERT;
                    count_next = count_reg + 1'b1;
                end
            end
            KIND_REMOVE: begin
                if (pos_ext >= cnt_ext) begin
                    imm_res.status = ST_RANGE;
                end else if (in_acc) begin
                    cmd.op     = OP_REMOVE;
                    count_next = count_reg - 1'b1;
                end
            end
            default: begin
            end
        endcase
        imm_res.found_position = '0;
        imm_res.found_payload  = '0;
        imm_res.occupancy      = OCC_W'(count_next);
    end

    always_comb begin
        srch_res.status         = tok[CAPACITY].found ? ST_OK : ST_MISS;
        srch_res.found_position = FPOS_W'(tok_pos[CAPACITY]);
        srch_res.found_payload  = tok[CAPACITY].payload;
        srch_res.occupancy      = OCC_W'(count_reg);
    end

    assign tok[0].active  = inject_reg;
    assign tok[0].found   = 1'b0;
    assign tok[0].payload = '0;
    assign tok_pos[0]     = '0;

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [KEY_W-1:0] lkey, rkey;
        logic [PAY_W-1:0] lpay, rpay;
        if (i == 0) begin : g_first
            assign lkey = in_key;
            assign lpay = in_payload;
        end else begin : g_inner_l
            assign lkey = cell_key[i-1];
            assign lpay = cell_payload[i-1];
        end
        if (i == CAPACITY - 1) begin : g_last
            assign rkey = cell_key[i];
            assign rpay = cell_payload[i];
        end else begin : g_inner_r
            assign rkey = cell_key[i+1];
            assign rpay = cell_payload[i+1];
        end
        oal_cell #(
            .CNT_W (CNT_W),
            .IDX_W (IDX_W),
            .INDEX (i)
        ) u_cell (
            .aclk          (aclk),
            .aresetn       (aresetn),
            .cmd           (cmd),
            .count         (count_reg),
            .query_key     (qkey_reg),
            .left_key      (lkey),
            .left_payload  (lpay),
            .right_key     (rkey),
            .right_payload (rpay),
            .tok_in        (tok[i]),
            .tok_pos_in    (tok_pos[i]),
            .key           (cell_key[i]),
            .payload       (cell_payload[i]),
            .tok_out       (tok[i+1]),
            .tok_pos_out   (tok_pos[i+1])
        );
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (in_acc && (in_kind == KIND_SEARCH)) begin
                    state_next = S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (done) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        s_tready = 1'b0;
        enq      = 1'b0;
        enq_data = imm_res;
        case (state_reg)
            S_IDLE: begin
                s_tready = (fifo_cnt_reg != 2'd2);
                enq      = in_acc && (in_kind != KIND_SEARCH);
            end
            S_SEARCH: begin
                enq      = done;
                enq_data = srch_res;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        fifo_cnt_next = fifo_cnt_reg;
        slot0_next    = slot0_reg;
        slot1_next    = slot1_reg;
        case (fifo_cnt_reg)
            2'd0: begin
                if (enq) begin
                    slot0_next    = enq_data;
                    fifo_cnt_next = 2'd1;
                end
            end
            2'd1: begin
                if (enq && deq) begin
                    slot0_next = enq_data;
                end else if (enq) begin
                    slot1_next    = enq_data;
                    fifo_cnt_next = 2'd2;
                end else if (deq) begin
                    fifo_cnt_next = 2'd0;
                end
            end
            2'd2: begin
                if (deq) begin
                    slot0_next = slot1_reg;
                    if (enq) begin
                        slot1_next = enq_data;
                    end else begin
                        fifo_cnt_next = 2'd1;
                    end
                end
            end
            default: begin
                fifo_cnt_next = 2'd0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            inject_reg   <= 1'b0;
            fifo_cnt_reg <= '0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            inject_reg   <= in_acc && (in_kind == KIND_SEARCH);
            fifo_cnt_reg <= fifo_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
        if (in_acc) begin
            qkey_reg <= in_key;
        end
    end

    assign m_tvalid = (fifo_cnt_reg != 2'd0);
    assign m_tuser  = slot0_reg.status;
    assign m_tdata  = {1'b0, slot0_reg.occupancy, slot0_reg.found_payload,
                       slot0_reg.found_position};

    a_no_accept_in_search: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SEARCH) |-> !s_tready)
        else $error("request accepted while a search is in flight");

    a_fifo_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fifo_cnt_reg <= 2'd2)
        else $error("output buffer count out of range");

    a_done_in_search: assert property (@(posedge aclk) disable iff (!aresetn)
        done |-> (state_reg == S_SEARCH))
        else $error("search token left the chain outside a search");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_search_count_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SEARCH) |=> $stable(count_reg))
        else $error("entry count changed during a search");

endmodule
